FILE: rtl/okq_pkg.sv
// Shared types and constants for the ordered key queue.
// Depends on nothing; every other file except okq_ram imports it.
package okq_pkg;

   // Operation codes carried in the request func field.
   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_POP    = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_EXISTS = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam int KEY_W  = 32;
   localparam int FILL_W = 5;

   typedef struct packed {
      logic [2:0]       func;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [KEY_W-1:0]  popped_key;
      logic              head_valid;
      logic [KEY_W-1:0]  head_key;
      logic [FILL_W-1:0] fill_count;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;     // capture request beat
      logic exec;     // exec-state part of the operation, walk setup
      logic walk;     // one step of the scan / compaction walk
      logic finish;   // commit walk results
      logic head_rd;  // read entry at head pointer
      logic head_ld;  // load head key from read data
      logic respond;  // register the result beat
   } okq_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic [2:0] op;
      logic       walk_done;
   } okq_stat_type;

endpackage

FILE: rtl/ordered_key_queue_with_delete_unit.sv
// Ordered key queue with delete by value: top level, controller + datapath.
// Remove and exists walk the stored entries, one RAM read per entry.
// One item in flight; busy is registered, rises after accept and is low again in the result strobe cycle.
// Reset is synchronous and active high: queue empty, no result pending.
// The result beat is shown for one cycle only; the receiver cannot stall it.
module ordered_key_queue_with_delete_unit #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  okq_pkg::req_type req_data,
   output logic             rsp_valid,
   output okq_pkg::rsp_type rsp_data
);
   import okq_pkg::*;

   // Command and status groups between the sequencer and the datapath.
   okq_cmd_type  cmd;
   okq_stat_type stat;

   // Controller: accepts the request beat, steps through exec, the entry walk
   // (remove/exists), the head reload (pop/remove), and emits the result beat.
   okq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .stat      (stat),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   // Datapath: entries live in a circular RAM, so pop only advances the head
   // pointer; remove compacts the survivors in place behind the read pointer.
   okq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

FILE: rtl/okq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module okq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/okq_dp.sv
// Datapath of the ordered key queue: circular entry store, pointers, walk
// counters and the result register. Depends on okq_pkg and okq_ram.
module okq_dp #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  okq_pkg::req_type      req_data,
   input  okq_pkg::okq_cmd_type  cmd,
   output okq_pkg::okq_stat_type stat,
   output okq_pkg::rsp_type      rsp_data
);
   import okq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;

   // head + offset, modulo DEPTH; the sum stays below twice DEPTH
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   req_type          req_ff, req_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    head_ff, head_in;
   logic [CW-1:0]    rd_off_ff, rd_off_in;
   logic [CW-1:0]    wr_off_ff, wr_off_in;
   logic             pend_ff, pend_in;
   logic             ok_ff, ok_in;
   logic [KEY_W-1:0] popped_ff, popped_in;
   logic [KEY_W-1:0] head_key_ff, head_key_in;
   rsp_type          rsp_ff, rsp_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [KEY_W-1:0] wr_data;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [KEY_W-1:0] rd_data;
   logic [31:0]      count_ext;
   logic             nonempty;

   okq_ram #(
      .WIDTH (KEY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign nonempty  = (count_ff != '0);
   assign count_ext = 32'(count_ff);

   always_comb begin
      req_in      = req_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      rd_off_in   = rd_off_ff;
      wr_off_in   = wr_off_ff;
      pend_in     = pend_ff;
      ok_in       = ok_ff;
      popped_in   = popped_ff;
      head_key_in = head_key_ff;
      rsp_in      = rsp_ff;
      wr_en       = 1'b0;
      wr_addr     = wrap_add(head_ff, count_ff);
      wr_data     = req_ff.key;
      rd_en       = 1'b0;
      rd_addr     = head_ff;

      if (cmd.load) begin
         req_in = req_data;
      end

      if (cmd.exec) begin
         rd_off_in = '0;
         wr_off_in = '0;
         pend_in   = 1'b0;
         popped_in = '0;
         ok_in     = 1'b0;
         case (req_ff.func)
            OP_PUSH: begin
               if (count_ff < CW'(DEPTH)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  ok_in    = 1'b1;
                  if (!nonempty) begin
                     head_key_in = req_ff.key;
                  end
               end
            end
            OP_POP: begin
               if (nonempty) begin
                  popped_in = head_key_ff;
                  head_in   = wrap_add(head_ff, CW'(1));
                  count_in  = count_ff - 1'b1;
                  ok_in     = 1'b1;
               end
            end
            OP_REMOVE: ok_in = 1'b1;
            OP_EXISTS: ok_in = 1'b0;
            OP_CLEAR: begin
               count_in = '0;
               ok_in    = 1'b1;
            end
            default: ok_in = 1'b0;
         endcase
      end

      // Each read is compared in the cycle after it is issued; writes trail reads.
      if (cmd.walk) begin
         if (rd_off_ff < count_ff) begin
            rd_en     = 1'b1;
            rd_addr   = wrap_add(head_ff, rd_off_ff);
            rd_off_in = rd_off_ff + 1'b1;
            pend_in   = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff) begin
            if (rd_data == req_ff.key) begin
               if (req_ff.func == OP_EXISTS) begin
                  ok_in = 1'b1;
               end
            end else if (req_ff.func == OP_REMOVE) begin
               wr_en     = 1'b1;
               wr_addr   = wrap_add(head_ff, wr_off_ff);
               wr_data   = rd_data;
               wr_off_in = wr_off_ff + 1'b1;
            end
         end
      end

      if (cmd.finish && (req_ff.func == OP_REMOVE)) begin
         count_in = wr_off_ff;
      end

      if (cmd.head_rd) begin
         rd_en   = 1'b1;
         rd_addr = head_ff;
      end

      if (cmd.head_ld && nonempty) begin
         head_key_in = rd_data;
      end

      if (cmd.respond) begin
         rsp_in.ok         = ok_ff;
         rsp_in.popped_key = popped_ff;
         rsp_in.head_valid = nonempty;
         rsp_in.head_key   = nonempty ? head_key_ff : '0;
         rsp_in.fill_count = count_ext[FILL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
         pend_ff  <= pend_in;
      end
      req_ff      <= req_in;
      rd_off_ff   <= rd_off_in;
      wr_off_ff   <= wr_off_in;
      ok_ff       <= ok_in;
      popped_ff   <= popped_in;
      head_key_ff <= head_key_in;
      rsp_ff      <= rsp_in;
   end

   assign stat.op        = req_ff.func;
   assign stat.walk_done = (rd_off_ff == count_ff) && !pend_ff;
   assign rsp_data       = rsp_ff;

endmodule

FILE: rtl/okq_ctrl.sv
// Controller state machine of the ordered key queue.
// Sequences the datapath through each operation. Depends on okq_pkg.
module okq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  okq_pkg::okq_stat_type stat,
   output okq_pkg::okq_cmd_type  cmd,
   output logic                  rsp_valid
);
   import okq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_FINISH,
      ST_HREAD,
      ST_HWAIT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.op inside {OP_REMOVE, OP_EXISTS}) begin
               state_in = ST_WALK;
            end else if (stat.op == OP_POP) begin
               state_in = ST_HREAD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (stat.walk_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = (stat.op == OP_REMOVE) ? ST_HREAD : ST_DONE;
         end
         ST_HREAD: begin
            cmd.head_rd = 1'b1;
            state_in    = ST_HWAIT;
         end
         ST_HWAIT: begin
            cmd.head_ld = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            cmd.respond  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/okq_chk.sv
// Port-level checker for the ordered key queue, bound to the top level.
// Depends on okq_pkg.
module okq_chk (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input okq_pkg::req_type req_data,
   input logic             rsp_valid,
   input okq_pkg::rsp_type rsp_data
);
   import okq_pkg::*;

   // A result beat lasts one cycle.
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // An accepted beat makes the unit busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("not busy after accept");

   // The result comes exactly as the unit goes idle.
   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result beat outside the end of an operation");

   // Empty queue reports a zero head key.
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.head_valid) |-> (rsp_data.head_key == '0))
      else $error("head key nonzero on empty queue");

   // A failed operation returns no popped key.
   a_popped_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> (rsp_data.popped_key == '0))
      else $error("popped key nonzero without success");

endmodule

bind ordered_key_queue_with_delete_unit okq_chk u_okq_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
